// ===== hw/rtl/brlt_pkg.sv =====
// shared types and constants for the byte range lock table
package brlt_pkg;

  localparam logic [1:0] OP_TEST   = 2'd0;
  localparam logic [1:0] OP_LOCK   = 2'd1;
  localparam logic [1:0] OP_UNLOCK = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CONFLICT = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [15:0] owner;
    logic [63:0] start;
    logic [63:0] length;
    logic        excl;
  } entry_t;

  // last byte of a range, all ones for length zero
  function automatic logic [63:0] range_end(input logic [63:0] s, input logic [63:0] l);
    range_end = (l == 64'd0) ? '1 : (s + l - 64'd1);
  endfunction

endpackage

// ===== hw/rtl/brlt_mem.sv =====
// entry storage: one write port, one registered read port
module brlt_mem #(
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  brlt_pkg::entry_t    wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output brlt_pkg::entry_t    rdata_o
);

  brlt_pkg::entry_t mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/byte_range_lock_table.sv =====
// byte range lock table top level with its sequencer
// Usage: drive the request fields and raise start; a request is taken at a rising
// edge where start is high and busy is low. The block walks the table entry by
// entry through a memory with one write port and one registered read port: each
// entry is read (S_READ) and then evaluated (S_EVAL). A test stops at its first
// hit, a lock at its owner's identical range, which it re-flags; an unlock scans
// every entry. An insert scans first and then, if the table is not full, shifts
// every entry up one slot and puts the new entry into slot 0. Each unlock remove
// or split also shifts the entries after it. One result per request appears on
// the result ports with done_o high for exactly one cycle; the receiver cannot
// stall it. busy is high from the cycle after acceptance through the done_o
// cycle, so the next request is taken in the cycle after done_o at the earliest.
// Reset empties the table (the fill count clears); entries past the count are
// never read, so the memory needs no clearing pass. The single read port, one
// entry at a time, sets the pace.
module byte_range_lock_table #(
  parameter int MAX_LOCKS = 16,
  parameter int OWNER_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [63:0] range_start_i,
  input  logic [63:0] range_length_i,
  input  logic        want_exclusive_i,
  input  logic [15:0] owner_id_i,
  input  logic        owner_given_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [63:0] hit_start_o,
  output logic [63:0] hit_length_o,
  output logic        hit_exclusive_o,
  output logic [15:0] hit_owner_o
);

  localparam int AW = (MAX_LOCKS > 1) ? $clog2(MAX_LOCKS) : 1;
  localparam int CW = $clog2(MAX_LOCKS + 1);
  localparam logic [15:0] OMASK = 16'((64'd1 << OWNER_BITS) - 64'd1);

  brlt_pkg::state_e state_q, state_d;
  logic [CW-1:0] n_q, n_d, i_q, i_d, k_q, k_d, stop_q, stop_d;
  logic          up_q, up_d;   // shift direction: 1 opens a slot
  logic          ret_q, ret_d; // after shift, return to scan
  logic [1:0]  op_q;
  logic [63:0] us_q, ul_q;
  logic        ex_q, given_q;
  logic [15:0] own_q;
  logic [1:0]  st_q, st_d;
  brlt_pkg::entry_t hit_q, hit_d;
  brlt_pkg::entry_t pend_q, pend_d; // entry written after the shift
  logic [CW-1:0] pend_a_q, pend_a_d;
  logic          pend_v_q, pend_v_d;
  logic          done_q, done_d;

  logic           we;
  logic [AW-1:0]  waddr, raddr;
  brlt_pkg::entry_t wdata, rdata;

  brlt_mem #(.DEPTH(MAX_LOCKS), .AW(AW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [63:0] ue, le;
  logic meet, own_m;
  assign ue = brlt_pkg::range_end(us_q, ul_q);
  assign le = brlt_pkg::range_end(rdata.start, rdata.length);
  assign meet = (rdata.start <= ue) && (us_q <= le);
  assign own_m = (rdata.owner == own_q);

  // request capture
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      op_q <= opcode_i; us_q <= range_start_i; ul_q <= range_length_i;
      ex_q <= want_exclusive_i; own_q <= owner_id_i & OMASK; given_q <= owner_given_i;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= brlt_pkg::S_IDLE; n_q <= '0; i_q <= '0; k_q <= '0; stop_q <= '0;
      up_q <= 1'b0; ret_q <= 1'b0; pend_v_q <= 1'b0; done_q <= 1'b0;
    end else begin
      state_q <= state_d; n_q <= n_d; i_q <= i_d; k_q <= k_d; stop_q <= stop_d;
      up_q <= up_d; ret_q <= ret_d; pend_v_q <= pend_v_d; done_q <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    st_q <= st_d; hit_q <= hit_d; pend_q <= pend_d; pend_a_q <= pend_a_d;
  end

  // sequencer
  always_comb begin
    state_d = state_q; n_d = n_q; i_d = i_q; k_d = k_q; stop_d = stop_q;
    up_d = up_q; ret_d = ret_q; st_d = st_q; hit_d = hit_q;
    pend_d = pend_q; pend_a_d = pend_a_q; pend_v_d = pend_v_q; done_d = 1'b0;
    we = 1'b0; waddr = i_q[AW-1:0]; wdata = rdata; raddr = i_q[AW-1:0];
    unique case (state_q)
      brlt_pkg::S_IDLE: begin
        if (start && !busy) begin
          i_d = '0; st_d = brlt_pkg::ST_OK; hit_d = '0; pend_v_d = 1'b0;
          state_d = brlt_pkg::S_READ;
        end
      end
      brlt_pkg::S_READ: begin
        raddr = i_q[AW-1:0];
        if (i_q >= n_q) begin
          // end of scan
          if (op_q == brlt_pkg::OP_LOCK) begin
            if (n_q == CW'(MAX_LOCKS)) begin
              st_d = brlt_pkg::ST_FULL; state_d = brlt_pkg::S_DONE;
            end else begin
              pend_d = '{owner: own_q, start: us_q, length: ul_q, excl: ex_q};
              pend_a_d = '0; pend_v_d = 1'b1; up_d = 1'b1; ret_d = 1'b0;
              k_d = n_q; stop_d = '0; n_d = n_q + 1'b1;
              state_d = brlt_pkg::S_SHIFT_RD;
            end
          end else state_d = brlt_pkg::S_DONE;
        end else state_d = brlt_pkg::S_EVAL;
      end
      brlt_pkg::S_EVAL: begin
        state_d = brlt_pkg::S_READ; i_d = i_q + 1'b1;
        unique case (op_q)
          brlt_pkg::OP_TEST: begin
            if ((ex_q || rdata.excl) && !(given_q && own_m) && meet) begin
              st_d = brlt_pkg::ST_CONFLICT; hit_d = rdata;
              state_d = brlt_pkg::S_DONE;
            end
          end
          brlt_pkg::OP_LOCK: begin
            if (own_m && rdata.start == us_q && rdata.length == ul_q) begin
              we = 1'b1; wdata = rdata; wdata.excl = ex_q;
              state_d = brlt_pkg::S_DONE;
            end
          end
          brlt_pkg::OP_UNLOCK: begin
            if (own_m && meet) begin
              if (us_q <= rdata.start && ue >= le) begin
                // remove: shift tail down
                up_d = 1'b0; k_d = i_q; stop_d = n_q - 1'b1; n_d = n_q - 1'b1;
                ret_d = 1'b1; i_d = i_q; pend_v_d = 1'b0;
                state_d = brlt_pkg::S_SHIFT_RD;
              end else if (us_q > rdata.start && ue < le) begin
                if (n_q == CW'(MAX_LOCKS)) begin
                  st_d = brlt_pkg::ST_FULL; state_d = brlt_pkg::S_DONE;
                end else begin
                  we = 1'b1; wdata = rdata; wdata.length = us_q - rdata.start;
                  pend_d = rdata; pend_d.start = ue + 64'd1;
                  pend_d.length = (rdata.length == 64'd0) ? 64'd0 : (le - ue);
                  pend_a_d = i_q + 1'b1; pend_v_d = 1'b1; up_d = 1'b1;
                  k_d = n_q; stop_d = i_q + 1'b1; n_d = n_q + 1'b1;
                  ret_d = 1'b1; i_d = i_q + CW'(2);
                  state_d = brlt_pkg::S_SHIFT_RD;
                end
              end else if (us_q <= rdata.start) begin
                we = 1'b1; wdata = rdata; wdata.start = ue + 64'd1;
                wdata.length = (rdata.length == 64'd0) ? 64'd0 : (le - ue);
              end else begin
                we = 1'b1; wdata = rdata; wdata.length = us_q - rdata.start;
              end
            end
          end
          default: state_d = brlt_pkg::S_DONE;
        endcase
      end
      brlt_pkg::S_SHIFT_RD: begin
        if (k_q == stop_q) begin
          if (pend_v_q) begin
            we = 1'b1; waddr = pend_a_q[AW-1:0]; wdata = pend_q;
          end
          state_d = ret_q ? brlt_pkg::S_READ : brlt_pkg::S_DONE;
        end else begin
          raddr = up_q ? AW'(k_q - 1'b1) : AW'(k_q + 1'b1);
          state_d = brlt_pkg::S_SHIFT_WR;
        end
      end
      brlt_pkg::S_SHIFT_WR: begin
        we = 1'b1; waddr = k_q[AW-1:0]; wdata = rdata;
        k_d = up_q ? k_q - 1'b1 : k_q + 1'b1;
        state_d = brlt_pkg::S_SHIFT_RD;
      end
      brlt_pkg::S_DONE: begin
        done_d = 1'b1; state_d = brlt_pkg::S_IDLE;
      end
      default: state_d = brlt_pkg::S_IDLE;
    endcase
  end

  // result presentation: done_q pulses while state is idle
  assign busy = (state_q != brlt_pkg::S_IDLE) || done_q;
  assign done_o = done_q;
  assign status_o = st_q;
  assign hit_start_o = hit_q.start;
  assign hit_length_o = hit_q.length;
  assign hit_exclusive_o = hit_q.excl;
  assign hit_owner_o = hit_q.owner;

endmodule

// ===== dv/tb_byte_range_lock_table.sv =====
// self-checking testbench for the byte range lock table
`timescale 1ns / 1ps

module tb_byte_range_lock_table;

  localparam int NUM_SLOTS   = 16;
  localparam int RAND_ITEMS  = 900;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] rs;
    logic [63:0] rl;
    logic        excl;
    logic [15:0] own;
    logic        given;
  } lock_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] hs;
    logic [63:0] hl;
    logic        hx;
    logic [15:0] ho;
  } lock_rsp_t;

  // directed row: request plus an optional typed-in answer
  typedef struct {
    lock_req_t req;
    bit        typed;
    lock_rsp_t rsp;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode_i = brlt_pkg::OP_TEST;
  logic [63:0] range_start_i = '0;
  logic [63:0] range_length_i = '0;
  logic        want_exclusive_i = 1'b0;
  logic [15:0] owner_id_i = '0;
  logic        owner_given_i = 1'b0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [63:0] hit_start_o;
  logic [63:0] hit_length_o;
  logic        hit_exclusive_o;
  logic [15:0] hit_owner_o;

  byte_range_lock_table u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .opcode_i(opcode_i), .range_start_i(range_start_i),
    .range_length_i(range_length_i), .want_exclusive_i(want_exclusive_i),
    .owner_id_i(owner_id_i), .owner_given_i(owner_given_i),
    .done_o(done_o), .status_o(status_o), .hit_start_o(hit_start_o),
    .hit_length_o(hit_length_o), .hit_exclusive_o(hit_exclusive_o),
    .hit_owner_o(hit_owner_o)
  );

  always #1 clk_i = ~clk_i;

  // shadow copy of the lock table
  logic [15:0] sh_owner [NUM_SLOTS];
  logic [63:0] sh_start [NUM_SLOTS];
  logic [63:0] sh_len   [NUM_SLOTS];
  logic        sh_excl  [NUM_SLOTS];
  int          sh_count = 0;

  lock_rsp_t   pending_rsp [$];
  int          err_count = 0;

  function automatic logic [63:0] last_byte(logic [63:0] s, logic [63:0] l);
    return (l == 64'd0) ? '1 : s + l - 64'd1;
  endfunction

  function automatic bit overlaps(logic [63:0] s1, logic [63:0] l1,
                                  logic [63:0] s2, logic [63:0] l2);
    return (s1 <= last_byte(s2, l2)) && (s2 <= last_byte(s1, l1));
  endfunction

  // shift [pos, sh_count) up one slot
  function automatic void open_hole(int pos);
    for (int k = sh_count; k > pos; k--) begin
      sh_owner[k] = sh_owner[k-1];
      sh_start[k] = sh_start[k-1];
      sh_len[k]   = sh_len[k-1];
      sh_excl[k]  = sh_excl[k-1];
    end
    sh_count++;
  endfunction

  function automatic void drop_slot(int pos);
    for (int k = pos; k + 1 < sh_count; k++) begin
      sh_owner[k] = sh_owner[k+1];
      sh_start[k] = sh_start[k+1];
      sh_len[k]   = sh_len[k+1];
      sh_excl[k]  = sh_excl[k+1];
    end
    sh_count--;
  endfunction

  // apply one request to the shadow table and return the answer
  function automatic lock_rsp_t apply_lock_req(lock_req_t r);
    lock_rsp_t   a;
    int          i;
    logic [63:0] ue, ls, ll, le;
    a = '{status: brlt_pkg::ST_OK, hs: '0, hl: '0, hx: 1'b0, ho: '0};
    case (r.op)
      brlt_pkg::OP_TEST: begin
        for (i = 0; i < sh_count; i++) begin
          if (!r.excl && !sh_excl[i]) continue;
          if (r.given && sh_owner[i] == r.own) continue;
          if (overlaps(sh_start[i], sh_len[i], r.rs, r.rl)) begin
            a = '{status: brlt_pkg::ST_CONFLICT, hs: sh_start[i], hl: sh_len[i],
                  hx: sh_excl[i], ho: sh_owner[i]};
            return a;
          end
        end
      end
      brlt_pkg::OP_LOCK: begin
        for (i = 0; i < sh_count; i++) begin
          if (sh_owner[i] == r.own && sh_start[i] == r.rs && sh_len[i] == r.rl) begin
            sh_excl[i] = r.excl;
            return a;
          end
        end
        if (sh_count >= NUM_SLOTS) begin
          a.status = brlt_pkg::ST_FULL;
          return a;
        end
        open_hole(0);
        sh_owner[0] = r.own;
        sh_start[0] = r.rs;
        sh_len[0]   = r.rl;
        sh_excl[0]  = r.excl;
      end
      brlt_pkg::OP_UNLOCK: begin
        ue = last_byte(r.rs, r.rl);
        i = 0;
        while (i < sh_count) begin
          ls = sh_start[i];
          ll = sh_len[i];
          le = last_byte(ls, ll);
          if (sh_owner[i] != r.own || !overlaps(ls, ll, r.rs, r.rl)) begin
            i++;
          end else if (r.rs <= ls && ue >= le) begin
            drop_slot(i);
          end else if (r.rs > ls && ue < le) begin
            // split: remainder goes right after the original
            if (sh_count >= NUM_SLOTS) begin
              a.status = brlt_pkg::ST_FULL;
              return a;
            end
            open_hole(i + 1);
            sh_owner[i+1] = sh_owner[i];
            sh_excl[i+1]  = sh_excl[i];
            sh_start[i+1] = ue + 64'd1;
            sh_len[i+1]   = (ll == 0) ? 64'd0 : le - ue;
            sh_len[i]     = r.rs - ls;
            i += 2;
          end else if (r.rs <= ls) begin
            sh_start[i] = ue + 64'd1;
            sh_len[i]   = (ll == 0) ? 64'd0 : le - ue;
            i++;
          end else begin
            sh_len[i] = r.rs - ls;
            i++;
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    lock_rsp_t w;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected result status", status_o, 0);
      end else begin
        w = pending_rsp.pop_front();
        if (status_o !== w.status) report_mismatch("status", status_o, w.status);
        if (hit_start_o !== w.hs) report_mismatch("hit_start", hit_start_o, w.hs);
        if (hit_length_o !== w.hl) report_mismatch("hit_length", hit_length_o, w.hl);
        if (hit_exclusive_o !== w.hx) report_mismatch("hit_excl", hit_exclusive_o, w.hx);
        if (hit_owner_o !== w.ho) report_mismatch("hit_owner", hit_owner_o, w.ho);
      end
    end
  end

  // random field pickers, biased toward small ranges and the top of the space
  function automatic logic [63:0] pick_offset();
    case ($urandom_range(0, 5))
      0, 1, 2: return 64'($urandom_range(0, 63));
      3:       return '1 - 64'($urandom_range(0, 63));
      4:       return {$urandom, $urandom};
      default: return 64'($urandom_range(0, 3)) << $urandom_range(0, 63);
    endcase
  endfunction

  function automatic logic [63:0] pick_length();
    case ($urandom_range(0, 6))
      0:       return 64'd0;
      1:       return '1;
      2:       return {$urandom, $urandom};
      default: return 64'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic lock_req_t pick_req();
    lock_req_t r;
    int        roll;
    roll = $urandom_range(0, 99);
    r.rs    = pick_offset();
    r.rl    = pick_length();
    r.excl  = 1'($urandom_range(0, 1));
    r.own   = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4));
    r.given = 1'($urandom_range(0, 1));
    if (roll < 45)      r.op = brlt_pkg::OP_LOCK;
    else if (roll < 70) r.op = brlt_pkg::OP_TEST;
    else if (roll < 97) r.op = brlt_pkg::OP_UNLOCK;
    else                r.op = brlt_pkg::OP_NOP;
    // occasional sweep clears an owner completely
    if (r.op == brlt_pkg::OP_UNLOCK && $urandom_range(0, 9) == 0) begin
      r.rs = '0;
      r.rl = '0;
    end
    return r;
  endfunction

  // drive one request, hold it until accepted, then predict
  task automatic send_req(lock_req_t r, int gap, bit typed, lock_rsp_t t);
    lock_rsp_t p;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start            <= 1'b1;
    opcode_i         <= r.op;
    range_start_i    <= r.rs;
    range_length_i   <= r.rl;
    want_exclusive_i <= r.excl;
    owner_id_i       <= r.own;
    owner_given_i    <= r.given;
    do @(posedge clk_i); while (busy !== 1'b0);
    p = apply_lock_req(r);
    if (typed && p != t) report_mismatch("typed answer status", t.status, p.status);
    pending_rsp.push_back(typed ? t : p);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  localparam lock_rsp_t RSP_NONE =
    '{status: brlt_pkg::ST_OK, hs: '0, hl: '0, hx: 1'b0, ho: '0};
  localparam lock_rsp_t RSP_FULL =
    '{status: brlt_pkg::ST_FULL, hs: '0, hl: '0, hx: 1'b0, ho: '0};

  dir_row_t dir_rows [] = '{
    // empty table: no conflict, unlock is a no-op
    '{'{brlt_pkg::OP_TEST, '1, '0, 1'b1, 16'hFFFF, 1'b0}, 1'b1, RSP_NONE},
    '{'{brlt_pkg::OP_UNLOCK, '0, '0, 1'b0, 16'h0000, 1'b0}, 1'b1, RSP_NONE},
    '{'{brlt_pkg::OP_NOP, '1, '1, 1'b1, 16'hFFFF, 1'b1}, 1'b1, RSP_NONE},
    // whole-file exclusive lock by owner 1
    '{'{brlt_pkg::OP_LOCK, '0, '0, 1'b1, 16'h0001, 1'b1}, 1'b1, RSP_NONE},
    '{'{brlt_pkg::OP_TEST, '1, 64'd1, 1'b0, 16'h0002, 1'b1}, 1'b1,
      '{brlt_pkg::ST_CONFLICT, 64'd0, 64'd0, 1'b1, 16'h0001}},
    '{'{brlt_pkg::OP_TEST, 64'd5, 64'd1, 1'b1, 16'h0001, 1'b1}, 1'b1, RSP_NONE},
    '{'{brlt_pkg::OP_TEST, 64'd5, 64'd1, 1'b1, 16'h0001, 1'b0}, 1'b0, RSP_NONE},
    // re-flag the identical range as shared, then shared test passes
    '{'{brlt_pkg::OP_LOCK, '0, '0, 1'b0, 16'h0001, 1'b0}, 1'b1, RSP_NONE},
    '{'{brlt_pkg::OP_TEST, 64'd9, 64'd3, 1'b0, 16'h0002, 1'b0}, 1'b1, RSP_NONE},
    '{'{brlt_pkg::OP_TEST, 64'd9, 64'd3, 1'b1, 16'h0002, 1'b0}, 1'b0, RSP_NONE},
    // split a to-end-of-file lock, then trim both pieces
    '{'{brlt_pkg::OP_UNLOCK, 64'd100, 64'd50, 1'b0, 16'h0001, 1'b0}, 1'b0, RSP_NONE},
    '{'{brlt_pkg::OP_UNLOCK, 64'd90, 64'd20, 1'b0, 16'h0001, 1'b0}, 1'b0, RSP_NONE},
    '{'{brlt_pkg::OP_UNLOCK, 64'd140, 64'd20, 1'b0, 16'h0001, 1'b0}, 1'b0, RSP_NONE},
    // last byte of the space, and a range that wraps past the top
    '{'{brlt_pkg::OP_LOCK, '1, 64'd1, 1'b1, 16'hFFFF, 1'b0}, 1'b0, RSP_NONE},
    '{'{brlt_pkg::OP_LOCK, 64'hFFFF_FFFF_FFFF_FFF0, 64'h20, 1'b1, 16'h0003, 1'b0},
      1'b0, RSP_NONE},
    '{'{brlt_pkg::OP_TEST, 64'd2, 64'd4, 1'b1, 16'h0004, 1'b0}, 1'b0, RSP_NONE},
    '{'{brlt_pkg::OP_TEST, '1, '1, 1'b1, 16'h0004, 1'b0}, 1'b0, RSP_NONE},
    // truncating the start up to wraparound keeps length zero
    '{'{brlt_pkg::OP_UNLOCK, 64'd0, '1, 1'b0, 16'h0001, 1'b0}, 1'b0, RSP_NONE},
    '{'{brlt_pkg::OP_UNLOCK, '1, '0, 1'b0, 16'hFFFF, 1'b0}, 1'b0, RSP_NONE},
    '{'{brlt_pkg::OP_UNLOCK, '0, '0, 1'b0, 16'h0001, 1'b0}, 1'b0, RSP_NONE},
    '{'{brlt_pkg::OP_UNLOCK, '0, '0, 1'b0, 16'h0003, 1'b0}, 1'b0, RSP_NONE}
  };

  // stimulus
  initial begin
    lock_req_t r;
    int        slot;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k])
      send_req(dir_rows[k].req, $urandom_range(0, 7), dir_rows[k].typed, dir_rows[k].rsp);
    drain();

    // fill the table, then add and split against a full table
    slot = 0;
    while (sh_count < NUM_SLOTS) begin
      r = '{brlt_pkg::OP_LOCK, 64'(slot * 100), 64'd10, slot[0], 16'h0007, 1'b0};
      send_req(r, $urandom_range(0, 2), 1'b0, RSP_NONE);
      slot++;
    end
    send_req('{brlt_pkg::OP_LOCK, 64'd5000, 64'd1, 1'b1, 16'h0008, 1'b0}, 0, 1'b1,
             RSP_FULL);
    send_req('{brlt_pkg::OP_LOCK, 64'd0, 64'd10, 1'b1, 16'h0007, 1'b0}, 0, 1'b1,
             RSP_NONE);
    send_req('{brlt_pkg::OP_UNLOCK, 64'd1502, 64'd2, 1'b0, 16'h0007, 1'b0}, 0, 1'b1,
             RSP_FULL);
    drain();
    send_req('{brlt_pkg::OP_UNLOCK, 64'd0, 64'd0, 1'b0, 16'h0007, 1'b0}, 0, 1'b0,
             RSP_NONE);

    // random traffic, with a burst phase without idling
    for (int n = 0; n < RAND_ITEMS; n++) begin
      r = pick_req();
      send_req(r, (n >= 300 && n < 400) ? 0 : $urandom_range(0, 7), 1'b0, RSP_NONE);
      if (n == 500) drain();
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (err_count == 0 && pending_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
